// ----- hdl/fau_pkg.sv -----
// ----------------------------------------------------------------------------
// fau_pkg
// Shared types and codes of the fraction arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } fau_act_t;

  typedef enum logic {
    MODE_GCD = 1'b0,
    MODE_DIV = 1'b1
  } fau_mode_t;

  // command from the sequencer to the shared iterative unit
  typedef struct packed {
    logic      start;
    fau_mode_t mode;
  } fau_cmd_t;

  localparam logic [30:0] RES_MAX = 31'h7fff_ffff;

endpackage

`default_nettype wire

// ----- hdl/fau_iter.sv -----
// ----------------------------------------------------------------------------
// fau_iter
// Shared iterative unit: binary gcd or restoring division, one step a cycle,
// both built around a single subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module fau_iter
  import fau_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fau_cmd_t      cmd,
  input  wire logic [DW-1:0] opx,
  input  wire logic [DW-1:0] opy,
  output logic               done,
  output logic [DW-1:0]      res
);

  localparam int CW = $clog2(DW + 1);

  typedef enum logic [3:0] {
    IT_IDLE = 4'b0001,
    IT_GCD  = 4'b0010,
    IT_SHL  = 4'b0100,
    IT_DIV  = 4'b1000
  } it_state_t;

  it_state_t       st_r, st_nxt;
  fau_mode_t       mode_r, mode_nxt;
  logic [DW-1:0]   u_r, u_nxt;
  logic [DW-1:0]   v_r, v_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;

  logic [DW:0]     sub_x, sub_y;
  logic [DW+1:0]   diff;
  logic            borrow;

  // the one subtractor
  always_comb begin
    if (st_r == IT_DIV) begin
      sub_x = {rem_r, u_r[DW-1]};
    end else begin
      sub_x = {1'b0, u_r};
    end
    sub_y  = {1'b0, v_r};
    diff   = {1'b0, sub_x} - {1'b0, sub_y};
    borrow = diff[DW+1];
  end

  always_comb begin
    st_nxt   = st_r;
    mode_nxt = mode_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      IT_IDLE: begin
        if (cmd.start) begin
          mode_nxt = cmd.mode;
          u_nxt    = opx;
          v_nxt    = opy;
          rem_nxt  = '0;
          k_nxt    = '0;
          cnt_nxt  = '0;
          st_nxt   = (cmd.mode == MODE_DIV) ? IT_DIV : IT_GCD;
        end
      end
      IT_GCD: begin
        if (u_r == '0) begin
          st_nxt = IT_SHL;
        end else if (v_r == '0) begin
          v_nxt  = u_r;
          st_nxt = IT_SHL;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (!borrow) begin
          u_nxt = diff[DW-1:0];
        end else begin
          // keep the larger value in u
          u_nxt = v_r;
          v_nxt = u_r;
        end
      end
      IT_SHL: begin
        // restore the common factors of two
        if (k_r == '0) begin
          done_nxt = 1'b1;
          st_nxt   = IT_IDLE;
        end else begin
          v_nxt = v_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      IT_DIV: begin
        if (!borrow) begin
          rem_nxt = diff[DW-1:0];
        end else begin
          rem_nxt = sub_x[DW-1:0];
        end
        u_nxt   = {u_r[DW-2:0], ~borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = IT_IDLE;
        end
      end
      default: begin
        st_nxt = IT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= IT_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = (mode_r == MODE_DIV) ? u_r : v_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> st_r == IT_IDLE)
    else $error("done raised while unit still busy");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != IT_IDLE) |-> !done_r)
    else $error("done while iterating");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == IT_DIV && v_r != '0) |-> rem_r < v_r)
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// ----- hdl/fraction_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// Add, subtract, multiply or divide two fractions; one result beat per input.
// ----------------------------------------------------------------------------
// One input beat is taken when the unit is idle and held until its result
// beat is taken. An add or subtract runs a binary gcd of the denominators
// and two restoring divisions, then three multiplies and a sum; multiply and
// divide run two multiplies, a gcd of the 2*OPERAND_WIDTH-bit products and
// two divisions. All gcd and division steps go through one shared
// subtract-and-shift unit. A zero product or a division by a zero fraction
// ends without the gcd and the divisions.
`default_nettype none

module fraction_arithmetic_unit
  import fau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // a_num, a_den, b_num, b_den, zero fill
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      in_tdata,
  // action
  input  wire logic [1:0]                                in_tuser,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // res_num, res_den, zero fill
  output logic [63:0]                                    out_tdata,
  // status
  output logic [0:0]                                     out_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;
  localparam int EW = (DW > 32) ? DW : 32;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_LOAD   = 14'b00000000000010,
    ST_L_GCD  = 14'b00000000000100,
    ST_L_DA   = 14'b00000000001000,
    ST_L_DB   = 14'b00000000010000,
    ST_L_M0   = 14'b00000000100000,
    ST_L_M1   = 14'b00000001000000,
    ST_L_M2   = 14'b00000010000000,
    ST_L_SUM  = 14'b00000100000000,
    ST_P_M0   = 14'b00001000000000,
    ST_P_M1   = 14'b00010000000000,
    ST_R_GCD  = 14'b00100000000000,
    ST_R_DN   = 14'b01000000000000,
    ST_R_DD   = 14'b10000000000000
  } st_t;

  st_t            st_r, st_nxt;
  logic           out_r, out_nxt;
  fau_act_t       act_r, act_nxt;
  logic           an_neg_r, an_neg_nxt, bn_neg_r, bn_neg_nxt;
  logic [W-1:0]   an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [W-1:0]   qa_r, qa_nxt, qb_r, qb_nxt;
  logic [DW-1:0]  g_r, g_nxt;
  logic [DW-1:0]  ta_r, ta_nxt, tb_r, tb_nxt;
  logic [DW-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic           neg_r, neg_nxt, status_r, status_nxt;

  // input decode
  logic [W-1:0]   f_an, f_ad, f_bn, f_bd;
  logic [W-1:0]   m_an, m_ad, m_bn, m_bd;

  // multiplier
  logic [W-1:0]   mul_x, mul_y;
  logic [DW-1:0]  mul_p;

  // shared unit
  fau_cmd_t       cmd;
  logic [DW-1:0]  it_x, it_y, it_res;
  logic           it_done;

  // signed-magnitude sum
  logic           tb_neg;
  logic           ta_ge;

  // output format
  logic [EW-1:0]  num_ext, den_ext;
  logic [30:0]    num_sat, den_sat;

  assign f_an = in_tdata[W-1:0];
  assign f_ad = in_tdata[2*W-1:W];
  assign f_bn = in_tdata[3*W-1:2*W];
  assign f_bd = in_tdata[4*W-1:3*W];

  // the most negative code keeps its magnitude as an unsigned value
  assign m_an = f_an[W-1] ? (~f_an + 1'b1) : f_an;
  assign m_ad = f_ad[W-1] ? (~f_ad + 1'b1) : f_ad;
  assign m_bn = f_bn[W-1] ? (~f_bn + 1'b1) : f_bn;
  assign m_bd = f_bd[W-1] ? (~f_bd + 1'b1) : f_bd;

  always_comb begin
    unique case (st_r)
      ST_L_M0: begin mul_x = qa_r; mul_y = bd_r; end
      ST_L_M1: begin mul_x = qb_r; mul_y = an_r; end
      ST_L_M2: begin mul_x = qa_r; mul_y = bn_r; end
      ST_P_M0: begin
        mul_x = an_r;
        mul_y = (act_r == ACT_MUL) ? bn_r : bd_r;
      end
      ST_P_M1: begin
        mul_x = ad_r;
        mul_y = (act_r == ACT_MUL) ? bd_r : bn_r;
      end
      default: begin mul_x = an_r; mul_y = bn_r; end
    endcase
    mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
  end

  assign tb_neg = bn_neg_r ^ ((act_r == ACT_SUB) && (bn_r != '0));
  assign ta_ge  = ta_r >= tb_r;

  always_comb begin
    st_nxt     = st_r;
    out_nxt    = out_r;
    act_nxt    = act_r;
    an_neg_nxt = an_neg_r;
    bn_neg_nxt = bn_neg_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    bn_nxt     = bn_r;
    bd_nxt     = bd_r;
    qa_nxt     = qa_r;
    qb_nxt     = qb_r;
    g_nxt      = g_r;
    ta_nxt     = ta_r;
    tb_nxt     = tb_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    neg_nxt    = neg_r;
    status_nxt = status_r;
    cmd.start  = 1'b0;
    cmd.mode   = MODE_GCD;
    it_x       = num_r;
    it_y       = den_r;
    unique case (st_r)
      ST_IDLE: begin
        if (out_r) begin
          if (out_tready) out_nxt = 1'b0;
        end else if (in_tvalid) begin
          act_nxt    = fau_act_t'(in_tuser);
          an_nxt     = m_an;
          bn_nxt     = m_bn;
          ad_nxt     = (f_ad == '0) ? W'(1) : m_ad;
          bd_nxt     = (f_bd == '0) ? W'(1) : m_bd;
          an_neg_nxt = (f_an[W-1] ^ f_ad[W-1]) && (f_an != '0);
          bn_neg_nxt = (f_bn[W-1] ^ f_bd[W-1]) && (f_bn != '0);
          status_nxt = 1'b0;
          st_nxt     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        unique case (act_r) inside
          ACT_ADD, ACT_SUB: begin
            cmd.start = 1'b1;
            it_x      = DW'(ad_r);
            it_y      = DW'(bd_r);
            st_nxt    = ST_L_GCD;
          end
          ACT_MUL: st_nxt = ST_P_M0;
          default: begin
            if (bn_r == '0) begin
              num_nxt    = '0;
              den_nxt    = DW'(1);
              neg_nxt    = 1'b0;
              status_nxt = 1'b1;
              out_nxt    = 1'b1;
              st_nxt     = ST_IDLE;
            end else begin
              st_nxt = ST_P_M0;
            end
          end
        endcase
      end
      ST_L_GCD: begin
        if (it_done) begin
          g_nxt     = it_res;
          cmd.start = 1'b1;
          cmd.mode  = MODE_DIV;
          it_x      = DW'(ad_r);
          it_y      = it_res;
          st_nxt    = ST_L_DA;
        end
      end
      ST_L_DA: begin
        if (it_done) begin
          qa_nxt    = it_res[W-1:0];
          cmd.start = 1'b1;
          cmd.mode  = MODE_DIV;
          it_x      = DW'(bd_r);
          it_y      = g_r;
          st_nxt    = ST_L_DB;
        end
      end
      ST_L_DB: begin
        if (it_done) begin
          qb_nxt = it_res[W-1:0];
          st_nxt = ST_L_M0;
        end
      end
      ST_L_M0: begin den_nxt = mul_p; st_nxt = ST_L_M1; end
      ST_L_M1: begin ta_nxt  = mul_p; st_nxt = ST_L_M2; end
      ST_L_M2: begin tb_nxt  = mul_p; st_nxt = ST_L_SUM; end
      ST_L_SUM: begin
        if (an_neg_r == tb_neg) begin
          num_nxt = ta_r + tb_r;
          neg_nxt = an_neg_r;
        end else if (ta_ge) begin
          num_nxt = ta_r - tb_r;
          neg_nxt = an_neg_r && (ta_r != tb_r);
        end else begin
          num_nxt = tb_r - ta_r;
          neg_nxt = tb_neg;
        end
        out_nxt = 1'b1;
        st_nxt  = ST_IDLE;
      end
      ST_P_M0: begin
        num_nxt = mul_p;
        neg_nxt = an_neg_r ^ bn_neg_r;
        st_nxt  = ST_P_M1;
      end
      ST_P_M1: begin
        if (num_r == '0) begin
          // zero product reads as 0/1
          den_nxt = DW'(1);
          neg_nxt = 1'b0;
          out_nxt = 1'b1;
          st_nxt  = ST_IDLE;
        end else begin
          den_nxt   = mul_p;
          cmd.start = 1'b1;
          it_x      = num_r;
          it_y      = mul_p;
          st_nxt    = ST_R_GCD;
        end
      end
      ST_R_GCD: begin
        if (it_done) begin
          g_nxt     = it_res;
          cmd.start = 1'b1;
          cmd.mode  = MODE_DIV;
          it_x      = num_r;
          it_y      = it_res;
          st_nxt    = ST_R_DN;
        end
      end
      ST_R_DN: begin
        if (it_done) begin
          num_nxt   = it_res;
          cmd.start = 1'b1;
          cmd.mode  = MODE_DIV;
          it_x      = den_r;
          it_y      = g_r;
          st_nxt    = ST_R_DD;
        end
      end
      ST_R_DD: begin
        if (it_done) begin
          den_nxt = it_res;
          out_nxt = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  fau_iter #(
    .DW(DW)
  ) u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .opx  (it_x),
    .opy  (it_y),
    .done (it_done),
    .res  (it_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      out_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      out_r <= out_nxt;
    end
    act_r    <= act_nxt;
    an_neg_r <= an_neg_nxt;
    bn_neg_r <= bn_neg_nxt;
    an_r     <= an_nxt;
    ad_r     <= ad_nxt;
    bn_r     <= bn_nxt;
    bd_r     <= bd_nxt;
    qa_r     <= qa_nxt;
    qb_r     <= qb_nxt;
    g_r      <= g_nxt;
    ta_r     <= ta_nxt;
    tb_r     <= tb_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    neg_r    <= neg_nxt;
    status_r <= status_nxt;
  end

  // saturate to the 32-bit numerator and 31-bit denominator
  assign num_ext = EW'(num_r);
  assign den_ext = EW'(den_r);
  assign num_sat = (num_ext > EW'(RES_MAX)) ? RES_MAX : num_ext[30:0];
  assign den_sat = (den_ext > EW'(RES_MAX)) ? RES_MAX : den_ext[30:0];

  assign in_tready  = (st_r == ST_IDLE) && !out_r;
  assign out_tvalid = out_r;
  assign out_tdata  = {1'b0, den_sat,
                       neg_r ? (~{1'b0, num_sat} + 1'b1) : {1'b0, num_sat}};
  assign out_tuser  = status_r;

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r) |-> (num_r == '0 && den_r == DW'(1)))
    else $error("division by zero fraction without 0/1 result");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[62:32] != '0)
    else $error("zero result denominator");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

endmodule

`default_nettype wire
